// ===== rtl/core/tss_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tss_pkg
// Shared types and constants of the time-slice task scheduler.
// ----------------------------------------------------------------------------
package tss_pkg;

  // Fixed field widths of the request and dispatch items
  localparam int REQ_W     = 3;
  localparam int TASK_ID_W = 4;
  localparam int PERIOD_W  = 16;
  localparam int TAG_W     = 32;
  localparam int TICK_CNT_W = 32;

  // Packed stream data widths (whole bytes)
  localparam int S_FIELDS_W = TASK_ID_W + PERIOD_W + TAG_W;
  localparam int S_DATA_W   = ((S_FIELDS_W + 7) / 8) * 8;
  localparam int M_FIELDS_W = TASK_ID_W + TAG_W;
  localparam int M_DATA_W   = ((M_FIELDS_W + 7) / 8) * 8;

  // Parameter defaults
  localparam int DEF_MAX_TASKS  = 16;
  localparam int DEF_TICK_SLOTS = 64;
  localparam int DEF_COUNT_BITS = 16;

  // Request codes
  typedef enum logic [REQ_W-1:0] {
    REQ_ADD    = 3'd0,
    REQ_WAKE   = 3'd1,
    REQ_NOTIFY = 3'd2,
    REQ_DELETE = 3'd3,
    REQ_TICK   = 3'd4,
    REQ_SCHED  = 3'd5
  } req_e;

  // Task slot status
  typedef enum logic [1:0] {
    ST_IDLE  = 2'd0,
    ST_WAIT  = 2'd1,
    ST_READY = 2'd2
  } status_t;

  // Field write enables of the task table
  typedef struct packed {
    logic period;
    logic count;
    logic arg;
  } task_we_t;

endpackage

// ===== rtl/core/tss_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tss_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module tss_ram #(
  parameter int WIDTH = 4,
  parameter int DEPTH = 16,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/core/tss_task_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tss_task_ram
// Task table: period, countdown and argument word per slot, with field
// write enables and one registered read port.
// ----------------------------------------------------------------------------
module tss_task_ram #(
  parameter int DEPTH = 16,
  parameter int CW    = 16,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                        clk,
  input  tss_pkg::task_we_t           we,
  input  logic [AW-1:0]               waddr,
  input  logic [CW-1:0]               wperiod,
  input  logic [CW-1:0]               wcount,
  input  logic [tss_pkg::TAG_W-1:0]   warg,
  input  logic [AW-1:0]               raddr,
  output logic [CW-1:0]               rperiod,
  output logic [CW-1:0]               rcount,
  output logic [tss_pkg::TAG_W-1:0]   rarg
);
  import tss_pkg::*;

  logic [CW-1:0]    period_mem [DEPTH];
  logic [CW-1:0]    count_mem  [DEPTH];
  logic [TAG_W-1:0] arg_mem    [DEPTH];

  // Write selected fields
  always_ff @(posedge clk) begin
    if (we.period) begin
      period_mem[waddr] <= wperiod;
    end
    if (we.count) begin
      count_mem[waddr] <= wcount;
    end
    if (we.arg) begin
      arg_mem[waddr] <= warg;
    end
  end

  // Registered read of the whole entry
  always_ff @(posedge clk) begin
    rperiod <= period_mem[raddr];
    rcount  <= count_mem[raddr];
    rarg    <= arg_mem[raddr];
  end

endmodule

// ===== rtl/core/time_slice_task_scheduler_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// time_slice_task_scheduler_top
// Task scheduler with ordered waiting and ready lists held in RAM, a task
// table RAM and a ring of pending tick bits, driven by one list sequencer.
// ----------------------------------------------------------------------------
//  Channel  Dir  Signals                     Contents
//  s_*      in   tvalid tready tuser tdata   tuser = req_type,
//                                            tdata = task_id, slice_period, task_tag
//  m_*      out  tvalid tready tdata tlast   tdata = run_task_id, run_tag,
//                                            tlast = last_of_run
//
//  After reset the tick ring is cleared, one slot a cycle, with s_tready low.
//  Add, tick, and wake or notify of an idle or ready slot need no list walk.
//  Wake or notify of a waiting slot, and delete of a listed slot, walk its list.
//  Schedule walks the waiting list when a tick is pending, then the ready
//  list: each list entry costs one list RAM read, one task RAM read and one
//  write-back. A stalled m_tready holds the sequencer.
// ----------------------------------------------------------------------------
module time_slice_task_scheduler_top #(
  parameter int MAX_TASKS  = tss_pkg::DEF_MAX_TASKS,
  parameter int TICK_SLOTS = tss_pkg::DEF_TICK_SLOTS,
  parameter int COUNT_BITS = tss_pkg::DEF_COUNT_BITS
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  // req_type[2:0]
  input  logic [tss_pkg::REQ_W-1:0]     s_tuser,
  // task_id[3:0], slice_period[19:4], task_tag[51:20], zero pad above
  input  logic [tss_pkg::S_DATA_W-1:0]  s_tdata,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // run_task_id[3:0], run_tag[35:4], zero pad above
  output logic [tss_pkg::M_DATA_W-1:0]  m_tdata,
  output logic                          m_tlast
);
  import tss_pkg::*;

  localparam int ID_W  = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int LEN_W = $clog2(MAX_TASKS + 1);
  localparam int TW    = $clog2(TICK_SLOTS);
  localparam int M_PAD_W = M_DATA_W - M_FIELDS_W;

  typedef enum logic [2:0] {S_CLEAR, S_IDLE, S_TCHK, S_RD, S_TK, S_OP} state_t;
  typedef enum logic [1:0] {MD_REMOVE, MD_CONSUME, MD_DISPATCH} mode_t;

  state_t state;
  mode_t  mode;
  logic   sel_ready;
  logic   post_wake;
  logic [ID_W-1:0]   tgt;
  logic [ID_W-1:0]   cur_id;
  logic [LEN_W-1:0]  i;
  logic [LEN_W-1:0]  n;
  logic [LEN_W-1:0]  wait_len;
  logic [LEN_W-1:0]  ready_len;
  logic [TW-1:0]     rp;
  logic [TW-1:0]     wp;
  logic [TW-1:0]     clr_idx;
  logic [TICK_CNT_W-1:0] tick_cnt;
  status_t status [MAX_TASKS];
  logic [MAX_TASKS-1:0] once;
  logic [TASK_ID_W-1:0] out_id;
  logic [TAG_W-1:0]     out_tag;

  // Memory port signals
  logic            w_we, r_we;
  logic [ID_W-1:0] w_waddr, w_wdata, w_raddr, w_rdata;
  logic [ID_W-1:0] r_waddr, r_wdata, r_raddr, r_rdata;
  task_we_t        t_we;
  logic [ID_W-1:0] t_waddr, t_raddr;
  logic [COUNT_BITS-1:0] t_wperiod, t_wcount, t_rperiod, t_rcount;
  logic [TAG_W-1:0] t_warg, t_rarg;
  logic          k_we;
  logic [TW-1:0] k_waddr, k_raddr;
  logic          k_wdata, k_rdata;

  // Request decode
  logic [TASK_ID_W-1:0]  tid_raw;
  logic [ID_W-1:0]       id_in;
  logic                  in_rng;
  logic [COUNT_BITS-1:0] per_in;
  logic [TAG_W-1:0]      tag_in;
  status_t               st_in;
  logic [ID_W-1:0]       lst_rd;
  logic [COUNT_BITS-1:0] cnt_dec;
  logic                  op_go;
  logic                  walk_end;
  logic [MAX_TASKS-1:0]  rdy_vec, wt_vec;

  assign tid_raw  = s_tdata[TASK_ID_W-1:0];
  assign id_in    = ID_W'(tid_raw);
  assign in_rng   = (int'(tid_raw) < MAX_TASKS);
  assign per_in   = COUNT_BITS'(s_tdata[TASK_ID_W+PERIOD_W-1:TASK_ID_W]);
  assign tag_in   = s_tdata[S_FIELDS_W-1:TASK_ID_W+PERIOD_W];
  assign st_in    = in_rng ? status[id_in] : ST_IDLE;
  assign s_tready = (state == S_IDLE);
  assign walk_end = (i == n);
  assign cnt_dec  = t_rcount - COUNT_BITS'(1);
  assign m_tdata  = {{M_PAD_W{1'b0}}, out_tag, out_id};

  // Pick the list that the walk reads
  always_comb begin
    if (mode == MD_DISPATCH || (mode == MD_REMOVE && sel_ready)) begin
      lst_rd = r_rdata;
    end else begin
      lst_rd = w_rdata;
    end
  end

  // Status views for checks
  always_comb begin
    for (int j = 0; j < MAX_TASKS; j++) begin
      rdy_vec[j] = (status[j] == ST_READY);
      wt_vec[j]  = (status[j] == ST_WAIT);
    end
  end

  // Drive memory ports from the sequencer state
  always_comb begin
    w_we      = 1'b0;
    w_waddr   = wait_len[ID_W-1:0];
    w_wdata   = cur_id;
    w_raddr   = i[ID_W-1:0];
    r_we      = 1'b0;
    r_waddr   = ready_len[ID_W-1:0];
    r_wdata   = cur_id;
    r_raddr   = i[ID_W-1:0];
    t_we      = '0;
    t_waddr   = cur_id;
    t_wperiod = per_in;
    t_wcount  = per_in;
    t_warg    = tag_in;
    t_raddr   = cur_id;
    k_we      = 1'b0;
    k_waddr   = rp;
    k_wdata   = 1'b0;
    k_raddr   = rp;
    op_go     = 1'b0;
    unique case (state)
      S_CLEAR: begin
        k_we    = 1'b1;
        k_waddr = clr_idx;
      end
      S_IDLE: begin
        if (s_tvalid) begin
          case (s_tuser)
            REQ_TICK: begin
              k_we    = 1'b1;
              k_waddr = wp;
              k_wdata = 1'b1;
            end
            REQ_ADD: begin
              if (in_rng && st_in == ST_IDLE) begin
                t_we    = '{period: 1'b1, count: 1'b1, arg: 1'b1};
                t_waddr = id_in;
                if (per_in == '0) begin
                  r_we    = 1'b1;
                  r_wdata = id_in;
                end else begin
                  w_we    = 1'b1;
                  w_wdata = id_in;
                end
              end
            end
            REQ_WAKE, REQ_NOTIFY: begin
              if (in_rng) begin
                t_we.period = 1'b1;
                t_we.arg    = 1'b1;
                t_we.count  = (st_in != ST_READY);
                t_waddr     = id_in;
                if (st_in == ST_IDLE) begin
                  r_we    = 1'b1;
                  r_wdata = id_in;
                end
              end
            end
            default: ;
          endcase
        end
      end
      S_TCHK: ;
      S_RD: begin
        if (walk_end) begin
          if (mode == MD_REMOVE && post_wake) begin
            r_we    = 1'b1;
            r_wdata = tgt;
          end
          if (mode == MD_CONSUME) begin
            k_we = 1'b1;
          end
        end
      end
      S_TK: begin
        t_raddr = lst_rd;
        if (mode == MD_REMOVE && lst_rd != tgt) begin
          if (sel_ready) begin
            r_we    = 1'b1;
            r_wdata = lst_rd;
          end else begin
            w_we    = 1'b1;
            w_wdata = lst_rd;
          end
        end
      end
      S_OP: begin
        if (mode == MD_CONSUME) begin
          t_we.count = 1'b1;
          if (cnt_dec == '0) begin
            t_wcount = t_rperiod;
            r_we     = 1'b1;
          end else begin
            t_wcount = cnt_dec;
            w_we     = 1'b1;
          end
        end else begin
          op_go = !m_tvalid || m_tready;
          if (op_go && !once[cur_id]) begin
            if (t_rperiod != '0) begin
              w_we = 1'b1;
            end else begin
              r_we = 1'b1;
            end
          end
        end
      end
      default: ;
    endcase
  end

  // Sequencer, list lengths, tick pointers and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      mode      <= MD_REMOVE;
      sel_ready <= 1'b0;
      post_wake <= 1'b0;
      clr_idx   <= '0;
      i         <= '0;
      n         <= '0;
      wait_len  <= '0;
      ready_len <= '0;
      rp        <= '0;
      wp        <= '0;
      tick_cnt  <= '0;
      m_tvalid  <= 1'b0;
      once      <= '0;
      for (int j = 0; j < MAX_TASKS; j++) begin
        status[j] <= ST_IDLE;
      end
    end else begin
      // Drop the result once taken
      if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      // List pushes
      if (w_we) begin
        wait_len        <= wait_len + LEN_W'(1);
        status[w_wdata] <= ST_WAIT;
      end
      if (r_we) begin
        ready_len       <= ready_len + LEN_W'(1);
        status[r_wdata] <= ST_READY;
      end
      unique case (state)
        S_CLEAR: begin
          clr_idx <= clr_idx + TW'(1);
          if (clr_idx == TW'(TICK_SLOTS - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (s_tvalid) begin
            case (s_tuser)
              REQ_TICK: begin
                tick_cnt <= tick_cnt + TICK_CNT_W'(1);
                if (tick_cnt == '1 || wp == TW'(TICK_SLOTS - 1)) begin
                  wp <= '0;
                end else begin
                  wp <= wp + TW'(1);
                end
              end
              REQ_WAKE, REQ_NOTIFY: begin
                if (in_rng) begin
                  if (s_tuser == REQ_NOTIFY) begin
                    once[id_in] <= 1'b1;
                  end
                  if (st_in == ST_WAIT) begin
                    mode      <= MD_REMOVE;
                    sel_ready <= 1'b0;
                    post_wake <= 1'b1;
                    tgt       <= id_in;
                    n         <= wait_len;
                    wait_len  <= '0;
                    i         <= '0;
                    state     <= S_RD;
                  end
                end
              end
              REQ_DELETE: begin
                if (in_rng && st_in != ST_IDLE) begin
                  mode      <= MD_REMOVE;
                  post_wake <= 1'b0;
                  tgt       <= id_in;
                  i         <= '0;
                  state     <= S_RD;
                  if (st_in == ST_READY) begin
                    sel_ready <= 1'b1;
                    n         <= ready_len;
                    ready_len <= '0;
                  end else begin
                    sel_ready <= 1'b0;
                    n         <= wait_len;
                    wait_len  <= '0;
                  end
                end
              end
              REQ_SCHED: begin
                state <= S_TCHK;
              end
              default: ;
            endcase
          end
        end
        S_TCHK: begin
          i     <= '0;
          state <= S_RD;
          if (k_rdata) begin
            mode     <= MD_CONSUME;
            n        <= wait_len;
            wait_len <= '0;
          end else begin
            mode      <= MD_DISPATCH;
            n         <= ready_len;
            ready_len <= '0;
          end
        end
        S_RD: begin
          if (walk_end) begin
            unique case (mode)
              MD_REMOVE: begin
                if (!post_wake) begin
                  status[tgt] <= ST_IDLE;
                end
                state <= S_IDLE;
              end
              MD_CONSUME: begin
                rp        <= (rp == TW'(TICK_SLOTS - 1)) ? '0 : rp + TW'(1);
                mode      <= MD_DISPATCH;
                n         <= ready_len;
                ready_len <= '0;
                i         <= '0;
              end
              MD_DISPATCH: begin
                state <= S_IDLE;
              end
              default: state <= S_IDLE;
            endcase
          end else begin
            state <= S_TK;
          end
        end
        S_TK: begin
          cur_id <= lst_rd;
          if (mode == MD_REMOVE) begin
            i     <= i + LEN_W'(1);
            state <= S_RD;
          end else begin
            state <= S_OP;
          end
        end
        S_OP: begin
          if (mode == MD_CONSUME) begin
            i     <= i + LEN_W'(1);
            state <= S_RD;
          end else if (op_go) begin
            m_tvalid <= 1'b1;
            out_id   <= TASK_ID_W'(cur_id);
            out_tag  <= t_rarg;
            m_tlast  <= ((i + LEN_W'(1)) == n);
            if (once[cur_id]) begin
              once[cur_id]   <= 1'b0;
              status[cur_id] <= ST_IDLE;
            end
            i     <= i + LEN_W'(1);
            state <= S_RD;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Waiting list
  tss_ram #(.WIDTH(ID_W), .DEPTH(MAX_TASKS)) u_wait_list (
    .clk   (clk),
    .we    (w_we),
    .waddr (w_waddr),
    .wdata (w_wdata),
    .raddr (w_raddr),
    .rdata (w_rdata)
  );

  // Ready list
  tss_ram #(.WIDTH(ID_W), .DEPTH(MAX_TASKS)) u_ready_list (
    .clk   (clk),
    .we    (r_we),
    .waddr (r_waddr),
    .wdata (r_wdata),
    .raddr (r_raddr),
    .rdata (r_rdata)
  );

  // Pending tick ring
  tss_ram #(.WIDTH(1), .DEPTH(TICK_SLOTS)) u_tick_ring (
    .clk   (clk),
    .we    (k_we),
    .waddr (k_waddr),
    .wdata (k_wdata),
    .raddr (k_raddr),
    .rdata (k_rdata)
  );

  // Task table
  tss_task_ram #(.DEPTH(MAX_TASKS), .CW(COUNT_BITS)) u_task_tbl (
    .clk     (clk),
    .we      (t_we),
    .waddr   (t_waddr),
    .wperiod (t_wperiod),
    .wcount  (t_wcount),
    .warg    (t_warg),
    .raddr   (t_raddr),
    .rperiod (t_rperiod),
    .rcount  (t_rcount),
    .rarg    (t_rarg)
  );

  // Lists never hold more entries than there are slots
  a_len_bound: assert property (@(posedge clk) disable iff (rst)
    (32'(wait_len) + 32'(ready_len)) <= 32'(MAX_TASKS))
    else $error("list lengths exceed task count");

  // Between requests the ready list matches the ready slots
  a_ready_cnt: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> ($countones(rdy_vec) == int'(ready_len)))
    else $error("ready list length mismatch");

  // Between requests the waiting list matches the waiting slots
  a_wait_cnt: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> ($countones(wt_vec) == int'(wait_len)))
    else $error("waiting list length mismatch");

  // A blocked dispatch holds its task
  a_disp_hold: assert property (@(posedge clk) disable iff (rst)
    (state == S_OP && mode == MD_DISPATCH && m_tvalid && !m_tready)
      |=> (state == S_OP && $stable(cur_id)))
    else $error("dispatch moved on while output blocked");

endmodule

// ===== test/time_slice_task_scheduler_top_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// time_slice_task_scheduler_top_test
// Drives random and directed scheduler requests into the task scheduler and
// checks every dispatch item against a behavioral scheduler model kept here.
// ----------------------------------------------------------------------------
module time_slice_task_scheduler_top_test;
  import tss_pkg::*;

  localparam int NTASK = 16;
  localparam int NSLOT = 64;
  localparam int LIMIT = 400000;

  // Request codes outside the defined set
  localparam logic [REQ_W-1:0] REQ_BAD_LO = 3'd6;
  localparam logic [REQ_W-1:0] REQ_BAD_HI = 3'd7;

  typedef struct packed {
    logic [REQ_W-1:0]     kind;
    logic [TASK_ID_W-1:0] id;
    logic [PERIOD_W-1:0]  period;
    logic [TAG_W-1:0]     tag;
  } request_t;

  typedef struct packed {
    logic [TASK_ID_W-1:0] id;
    logic [TAG_W-1:0]     tag;
    logic                 last;
  } dispatch_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [REQ_W-1:0] s_tuser = '0;
  logic [S_DATA_W-1:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [M_DATA_W-1:0] m_tdata;
  logic m_tlast;

  time_slice_task_scheduler_top dut (.*);

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Scheduler model state
  status_t             slot_state [NTASK];
  logic [PERIOD_W-1:0] slot_period [NTASK];
  logic [PERIOD_W-1:0] slot_count [NTASK];
  logic [TAG_W-1:0]    slot_tag [NTASK];
  logic                slot_once [NTASK];
  logic [3:0]          waiting [$];
  logic [3:0]          runnable [$];
  logic                tick_ring [NSLOT];
  logic [5:0]          tick_rd;
  logic [31:0]         tick_wr;

  request_t  pending_reqs [$];
  dispatch_t expected_runs [$];
  int        mismatches = 0;
  int        cycles = 0;
  int        send_idle_pct = 23;
  int        recv_idle_pct = 76;
  bit        sent_now = 1'b0;

  function automatic void drop_from(ref logic [3:0] lst [$], input logic [3:0] id);
    for (int i = lst.size() - 1; i >= 0; i--)
      if (lst[i] == id) lst.delete(i);
  endfunction

  // Apply one request to the model and queue the dispatches it causes
  function automatic void predict_request(request_t r);
    logic [3:0] snap [$];
    logic [3:0] id;
    id = r.id;
    case (r.kind)
      REQ_TICK: begin
        tick_ring[tick_wr[5:0]] = 1'b1;
        tick_wr++;
      end
      REQ_SCHED: begin
        if (tick_ring[tick_rd]) begin
          snap = waiting;
          waiting = {};
          foreach (snap[i]) begin
            slot_count[snap[i]]--;
            if (slot_count[snap[i]] == 0) begin
              slot_count[snap[i]] = slot_period[snap[i]];
              slot_state[snap[i]] = ST_READY;
              runnable.push_back(snap[i]);
            end else begin
              waiting.push_back(snap[i]);
            end
          end
          tick_ring[tick_rd] = 1'b0;
          tick_rd++;
        end
        snap = runnable;
        runnable = {};
        foreach (snap[i]) begin
          expected_runs.push_back('{snap[i], slot_tag[snap[i]], i == snap.size() - 1});
          if (slot_once[snap[i]]) begin
            slot_once[snap[i]] = 1'b0;
            slot_state[snap[i]] = ST_IDLE;
          end else if (slot_period[snap[i]] != 0) begin
            slot_state[snap[i]] = ST_WAIT;
            waiting.push_back(snap[i]);
          end else begin
            slot_state[snap[i]] = ST_READY;
            runnable.push_back(snap[i]);
          end
        end
      end
      REQ_ADD: begin
        if (slot_state[id] == ST_IDLE) begin
          slot_period[id] = r.period;
          slot_count[id] = r.period;
          slot_tag[id] = r.tag;
          if (r.period == 0) begin
            slot_state[id] = ST_READY;
            runnable.push_back(id);
          end else begin
            slot_state[id] = ST_WAIT;
            waiting.push_back(id);
          end
        end
      end
      REQ_WAKE, REQ_NOTIFY: begin
        if (r.kind == REQ_NOTIFY) slot_once[id] = 1'b1;
        slot_period[id] = r.period;
        slot_tag[id] = r.tag;
        if (slot_state[id] != ST_READY) begin
          if (slot_state[id] == ST_WAIT) drop_from(waiting, id);
          slot_count[id] = r.period;
          slot_state[id] = ST_READY;
          runnable.push_back(id);
        end
      end
      REQ_DELETE: begin
        if (slot_state[id] == ST_WAIT) drop_from(waiting, id);
        else if (slot_state[id] == ST_READY) drop_from(runnable, id);
        slot_state[id] = ST_IDLE;
      end
      default: ;
    endcase
  endfunction

  // Random request: a mix of lifecycle, tick and schedule traffic with mostly small periods
  function automatic request_t random_request();
    request_t r;
    int pick;
    pick = $urandom_range(0, 99);
    r.id = TASK_ID_W'($urandom_range(0, NTASK - 1));
    r.tag = $urandom;
    case ($urandom_range(0, 9))
      0: r.period = PERIOD_W'($urandom);
      1, 2: r.period = '0;
      default: r.period = PERIOD_W'($urandom_range(1, 4));
    endcase
    if (pick < 18) r.kind = REQ_ADD;
    else if (pick < 26) r.kind = REQ_WAKE;
    else if (pick < 32) r.kind = REQ_NOTIFY;
    else if (pick < 40) r.kind = REQ_DELETE;
    else if (pick < 68) r.kind = REQ_TICK;
    else if (pick < 97) r.kind = REQ_SCHED;
    else r.kind = REQ_W'($urandom_range(REQ_BAD_LO, REQ_BAD_HI));
    return r;
  endfunction

  // Predict each accepted item and retire it from the pending queue
  always @(posedge clk) begin
    sent_now <= 1'b0;
    if (!rst && s_tvalid && s_tready) begin
      predict_request(request_t'{kind: s_tuser, id: s_tdata[3:0],
                                 period: s_tdata[19:4], tag: s_tdata[51:20]});
      void'(pending_reqs.pop_front());
      sent_now <= 1'b1;
    end
  end

  // Drive: present the next item on the falling edge
  always @(negedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || sent_now) begin
      if (pending_reqs.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        s_tvalid <= 1'b1;
        s_tuser <= pending_reqs[0].kind;
        s_tdata <= S_DATA_W'({pending_reqs[0].tag, pending_reqs[0].period,
                              pending_reqs[0].id});
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // Receiver stalls on the falling edge, result check at the rising edge
  always @(negedge clk)
    m_tready <= !rst && ($urandom_range(0, 99) >= recv_idle_pct);

  always @(posedge clk) begin
    dispatch_t want;
    cycles <= cycles + 1;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_runs.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected dispatch id=%0d tag=%h last=%b",
                   m_tdata[3:0], m_tdata[35:4], m_tlast);
      end else begin
        want = expected_runs.pop_front();
        if (m_tdata[3:0] !== want.id || m_tdata[35:4] !== want.tag ||
            m_tlast !== want.last || m_tdata[M_DATA_W-1:36] !== '0) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"dispatch mismatch: expected id=%0d tag=%h last=%b, ",
                      "got id=%0d tag=%h last=%b"},
                     want.id, want.tag, want.last, m_tdata[3:0], m_tdata[35:4], m_tlast);
        end
      end
    end
    if (cycles > LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

  task automatic add_req(logic [REQ_W-1:0] k, int id, int period, logic [31:0] tag);
    request_t r;
    r.kind = k;
    r.id = TASK_ID_W'(id);
    r.period = PERIOD_W'(period);
    r.tag = tag;
    pending_reqs.push_back(r);
  endtask

  task automatic drain();
    while (pending_reqs.size() > 0 || s_tvalid) @(posedge clk);
    while (expected_runs.size() > 0) @(posedge clk);
  endtask

  initial begin
    request_t r;
    for (int i = 0; i < NTASK; i++) begin
      slot_state[i] = ST_IDLE;
      slot_period[i] = '0;
      slot_count[i] = '0;
      slot_tag[i] = '0;
      slot_once[i] = 1'b0;
    end
    foreach (tick_ring[i]) tick_ring[i] = 1'b0;
    tick_rd = '0;
    tick_wr = '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed: extremes, every request kind, list edge cases
    add_req(REQ_SCHED, 0, 0, 0);
    add_req(REQ_ADD, 0, 0, 32'hFFFF_FFFF);
    add_req(REQ_ADD, 15, 16'hFFFF, 32'h0000_0000);
    add_req(REQ_ADD, 0, 5, 32'h1234_5678);
    add_req(REQ_ADD, 7, 1, 32'hA5A5_5A5A);
    add_req(REQ_NOTIFY, 3, 2, 32'h5A5A_A5A5);
    add_req(REQ_SCHED, 0, 0, 0);
    add_req(REQ_TICK, 0, 0, 0);
    add_req(REQ_TICK, 0, 0, 0);
    add_req(REQ_SCHED, 0, 0, 0);
    add_req(REQ_SCHED, 0, 0, 0);
    add_req(REQ_WAKE, 15, 0, 32'hDEAD_BEEF);
    add_req(REQ_WAKE, 0, 3, 32'hCAFE_F00D);
    add_req(REQ_DELETE, 7, 0, 0);
    add_req(REQ_DELETE, 9, 0, 0);
    add_req(REQ_BAD_LO, 1, 16'hFFFF, 32'hFFFF_FFFF);
    add_req(REQ_BAD_HI, 2, 0, 0);
    add_req(REQ_SCHED, 0, 0, 0);
    add_req(REQ_DELETE, 0, 0, 0);
    add_req(REQ_SCHED, 0, 0, 0);
    drain();

    // Random traffic in three phases, each drained until all dispatches are out
    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 23 : (phase == 1) ? 76 : 0;
      recv_idle_pct = (phase == 0) ? 76 : (phase == 1) ? 23 : 0;
      for (int n = 0; n < 97; n++) begin
        r = random_request();
        pending_reqs.push_back(r);
      end
      drain();
    end

    repeat (200) @(posedge clk);
    if (mismatches == 0 && expected_runs.size() == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end
endmodule

// ===== sim.f =====
rtl/core/tss_pkg.sv
rtl/core/tss_ram.sv
rtl/core/tss_task_ram.sv
rtl/core/time_slice_task_scheduler_top.sv
test/time_slice_task_scheduler_top_test.sv
